FILE: sv/em2c_pkg.sv
// ----------------------------------------------------------------------------
// Epoch millisecond conversion package
// Payload types and constants shared by the conversion unit and its parts.
// ----------------------------------------------------------------------------
package em2c_pkg;

  // Width of one pass through the shared divider.
  localparam int DivW = 32;

  // Bias that keeps the timestamp positive: 800 whole 400-year cycles of days,
  // a multiple of seven as well.
  localparam logic [54:0] BiasMs = 55'd10098224640000000;
  localparam logic [27:0] DaysTo0301 = 28'd719468;
  localparam logic [19:0] BiasYears = 20'd320000;

  // Divisors of the conversion and their reciprocals, floor(2^32 / d). For any
  // dividend below 2^32 the quotient taken from a reciprocal is exact or one
  // too small.
  localparam logic [DivW-1:0] MsPerSec     = 32'd1000;
  localparam logic [DivW-1:0] RcpSec       = 32'd4294967;
  localparam logic [DivW-1:0] SixtyDiv     = 32'd60;
  localparam logic [DivW-1:0] RcpSixty     = 32'd71582788;
  localparam logic [DivW-1:0] HrsPerDay    = 32'd24;
  localparam logic [DivW-1:0] RcpDay       = 32'd178956970;
  localparam logic [DivW-1:0] DaysPerWeek  = 32'd7;
  localparam logic [DivW-1:0] RcpWeek      = 32'd613566756;
  localparam logic [DivW-1:0] DaysPerEra   = 32'd146097;
  localparam logic [DivW-1:0] RcpEra       = 32'd29398;
  localparam logic [DivW-1:0] DaysPer4Yr   = 32'd1460;
  localparam logic [DivW-1:0] Rcp4Yr       = 32'd2941758;
  localparam logic [DivW-1:0] DaysPer100Yr = 32'd36524;
  localparam logic [DivW-1:0] Rcp100Yr     = 32'd117593;
  localparam logic [DivW-1:0] DaysPerYr    = 32'd365;
  localparam logic [DivW-1:0] RcpYr        = 32'd11767033;
  localparam logic [DivW-1:0] YrsPerCent   = 32'd100;
  localparam logic [DivW-1:0] RcpCent      = 32'd42949672;
  localparam logic [DivW-1:0] MonthSpanDays = 32'd153;
  localparam logic [DivW-1:0] RcpMonthSpan = 32'd28071681;
  localparam logic [DivW-1:0] MonthSpanLen = 32'd5;
  localparam logic [DivW-1:0] RcpFive      = 32'd858993459;

  typedef struct packed {
    logic signed [53:0] time_ms;
    logic               use_local;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         millisecond;
    logic [2:0]         weekday;
    logic signed [11:0] applied_offset;
  } out_item_t;

endpackage

FILE: sv/em2c_div.sv
// ----------------------------------------------------------------------------
// Shared constant divider
// Divides by a constant through its reciprocal on one shared multiplier,
// then corrects the quotient once; done pulses when finished.
// ----------------------------------------------------------------------------
module em2c_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [em2c_pkg::DivW-1:0]    dividend,
  input  logic [em2c_pkg::DivW-1:0]    divisor,
  input  logic [em2c_pkg::DivW-1:0]    recip,
  output logic                         done,
  output logic [em2c_pkg::DivW-1:0]    quot,
  output logic [em2c_pkg::DivW-1:0]    rem
);

  typedef enum logic [1:0] {PH_IDLE, PH_EST, PH_BACK, PH_FIX} phase_t;

  phase_t                      phase;
  logic [em2c_pkg::DivW-1:0]   num;
  logic [em2c_pkg::DivW-1:0]   dsr;
  logic [em2c_pkg::DivW-1:0]   rcp;
  logic [em2c_pkg::DivW-1:0]   est;
  logic [2*em2c_pkg::DivW-1:0] prod;
  logic [em2c_pkg::DivW-1:0]   mul_a;
  logic [em2c_pkg::DivW-1:0]   mul_b;
  logic [em2c_pkg::DivW-1:0]   diff;

  // The multiplier first forms dividend times reciprocal, then the estimate
  // times the divisor, so that the remainder can be checked.
  always_comb begin
    mul_a = (phase == PH_EST) ? num : prod[2*em2c_pkg::DivW-1:em2c_pkg::DivW];
    mul_b = (phase == PH_EST) ? rcp : dsr;
    diff  = num - prod[em2c_pkg::DivW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            num   <= dividend;
            dsr   <= divisor;
            rcp   <= recip;
            phase <= PH_EST;
          end
        end
        PH_EST: begin
          prod  <= 64'(mul_a) * 64'(mul_b);
          phase <= PH_BACK;
        end
        PH_BACK: begin
          est   <= prod[2*em2c_pkg::DivW-1:em2c_pkg::DivW];
          prod  <= 64'(mul_a) * 64'(mul_b);
          phase <= PH_FIX;
        end
        PH_FIX: begin
          // The estimate is at most one short, so one step puts it right.
          if (diff >= dsr) begin
            quot <= est + 32'd1;
            rem  <= diff - dsr;
          end else begin
            quot <= est;
            rem  <= diff;
          end
          done  <= 1'b1;
          phase <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/epoch_ms_to_calendar_fields_unit.sv
// ----------------------------------------------------------------------------
// Epoch milliseconds to calendar fields
// Splits a signed millisecond timestamp into Gregorian date and time fields.
// ----------------------------------------------------------------------------
// The item takes 24 passes through the shared divider, and the result is
// then loaded into the output register. One item is converted at a time:
// the input stalls from acceptance until the result is loaded, and a
// waiting result holds the next item at its last step.
// Synchronous active-high reset clears the sequencer, the output valid flag
// and the zone offset (to zero).
// ----------------------------------------------------------------------------
module epoch_ms_to_calendar_fields_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [11:0]         cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  em2c_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output em2c_pkg::out_item_t out_data
);

  typedef enum logic [1:0] {IDLE, RUN, WAIT, OUT} state_t;

  // Each step is one division; the first four divide the wide timestamp
  // sixteen bits at a time, one divider pass per chunk.
  typedef enum logic [3:0] {
    ST_MS, ST_SEC, ST_MIN, ST_HR, ST_WDAY, ST_ERA, ST_A, ST_B,
    ST_YOE, ST_C100, ST_MP, ST_DOM
  } step_t;

  state_t state;
  step_t  step;

  logic signed [11:0] zone;
  logic signed [11:0] tz;

  // Wide value being divided, shifted left a chunk per pass while the
  // quotient chunks enter at the bottom, and the remainder carried between.
  logic [63:0] acc;
  logic [15:0] part_rem;
  logic [1:0]  chunk;

  // Intermediate results of the conversion.
  logic [10:0] era;
  logic [17:0] doe;
  logic [17:0] x;
  logic [8:0]  yoe;
  logic [8:0]  doy;
  logic [3:0]  mp;
  logic [4:0]  hr;
  logic [5:0]  mn;
  logic [5:0]  sc;
  logic [9:0]  ms;
  logic [2:0]  wd;
  logic [4:0]  dom;

  logic                         div_start;
  logic [em2c_pkg::DivW-1:0]    div_n;
  logic [em2c_pkg::DivW-1:0]    div_d;
  logic [em2c_pkg::DivW-1:0]    div_m;
  logic                         div_done;
  logic [em2c_pkg::DivW-1:0]    div_q;
  logic [em2c_pkg::DivW-1:0]    div_r;

  logic signed [11:0] tz_sel;
  logic signed [27:0] off_ms;
  logic [54:0]        tbias_next;
  logic [19:0]        year_next;
  logic [17:0]        yoe_terms;
  logic [27:0]        dbias;
  logic [31:0]        chunk_num;

  assign in_stall  = (state != IDLE);
  assign div_start = (state == RUN);

  // Once the hours are divided out, the accumulator holds the biased day.
  assign dbias     = acc[27:0];
  assign chunk_num = {part_rem, acc[63:48]};

  // The offset in milliseconds and the bias are folded in as the item enters,
  // so that every later division works on a positive value.
  always_comb begin
    tz_sel     = in_data.use_local ? zone : 12'sd0;
    off_ms     = 28'(tz_sel * 28'sd60000);
    tbias_next = {in_data.time_ms[53], in_data.time_ms}
               + {{27{off_ms[27]}}, off_ms} + em2c_pkg::BiasMs;
  end

  // Operand selection for the shared divider, one set per step.
  always_comb begin
    div_n = '0;
    div_d = 32'd1;
    div_m = '0;
    case (step)
      ST_MS: begin
        div_n = chunk_num;
        div_d = em2c_pkg::MsPerSec;
        div_m = em2c_pkg::RcpSec;
      end
      ST_SEC, ST_MIN: begin
        div_n = chunk_num;
        div_d = em2c_pkg::SixtyDiv;
        div_m = em2c_pkg::RcpSixty;
      end
      ST_HR: begin
        div_n = chunk_num;
        div_d = em2c_pkg::HrsPerDay;
        div_m = em2c_pkg::RcpDay;
      end
      ST_WDAY: begin
        div_n = 32'(dbias + 28'd4);
        div_d = em2c_pkg::DaysPerWeek;
        div_m = em2c_pkg::RcpWeek;
      end
      ST_ERA: begin
        div_n = 32'(dbias + em2c_pkg::DaysTo0301);
        div_d = em2c_pkg::DaysPerEra;
        div_m = em2c_pkg::RcpEra;
      end
      ST_A: begin
        div_n = 32'(doe);
        div_d = em2c_pkg::DaysPer4Yr;
        div_m = em2c_pkg::Rcp4Yr;
      end
      ST_B: begin
        div_n = 32'(doe);
        div_d = em2c_pkg::DaysPer100Yr;
        div_m = em2c_pkg::Rcp100Yr;
      end
      ST_YOE: begin
        div_n = 32'(x);
        div_d = em2c_pkg::DaysPerYr;
        div_m = em2c_pkg::RcpYr;
      end
      ST_C100: begin
        div_n = 32'(yoe);
        div_d = em2c_pkg::YrsPerCent;
        div_m = em2c_pkg::RcpCent;
      end
      ST_MP: begin
        div_n = 32'({doy, 2'b00} + 11'(doy) + 11'd2);
        div_d = em2c_pkg::MonthSpanDays;
        div_m = em2c_pkg::RcpMonthSpan;
      end
      ST_DOM: begin
        div_n = 32'(12'(mp) * 12'd153 + 12'd2);
        div_d = em2c_pkg::MonthSpanLen;
        div_m = em2c_pkg::RcpFive;
      end
      default: begin
        div_n = '0;
        div_d = 32'd1;
        div_m = '0;
      end
    endcase
  end

  // 365 * yoe + yoe / 4, the days of the whole years in the era so far,
  // before the century correction.
  assign yoe_terms = 18'(yoe) * 18'd365 + 18'(yoe[8:2]);

  // The year counts from March, so January and February belong to the next.
  assign year_next = 20'(era) * 20'd400 + 20'(yoe) - em2c_pkg::BiasYears
                   + ((mp >= 4'd10) ? 20'd1 : 20'd0);

  em2c_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .recip    (div_m),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      step      <= ST_MS;
      chunk     <= 2'd0;
      part_rem  <= 16'd0;
      zone      <= 12'sd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        zone <= cfg_wr_data;
      end
      // In OUT the output register is either kept or reloaded below.
      if (out_valid && !out_stall && state != OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            tz       <= tz_sel;
            acc      <= {9'd0, tbias_next};
            part_rem <= 16'd0;
            chunk    <= 2'd0;
            step     <= ST_MS;
            state    <= RUN;
          end
        end
        RUN: begin
          state <= WAIT;
        end
        WAIT: begin
          if (div_done) begin
            state <= RUN;
            case (step)
              ST_MS, ST_SEC, ST_MIN, ST_HR: begin
                acc   <= {acc[47:0], div_q[15:0]};
                chunk <= chunk + 2'd1;
                if (chunk == 2'd3) begin
                  // The last chunk leaves the remainder of the whole value.
                  part_rem <= 16'd0;
                  step     <= step_t'(step + 4'd1);
                  if (step == ST_MS) ms <= div_r[9:0];
                  if (step == ST_SEC) sc <= div_r[5:0];
                  if (step == ST_MIN) mn <= div_r[5:0];
                  if (step == ST_HR) hr <= div_r[4:0];
                end else begin
                  part_rem <= div_r[15:0];
                end
              end
              ST_WDAY: begin
                wd   <= div_r[2:0];
                step <= step_t'(step + 4'd1);
              end
              ST_ERA: begin
                era  <= div_q[10:0];
                doe  <= div_r[17:0];
                step <= step_t'(step + 4'd1);
              end
              ST_A: begin
                x    <= doe - div_q[17:0];
                step <= step_t'(step + 4'd1);
              end
              ST_B: begin
                // Last day of a 400-year cycle is the leap day of its year.
                x    <= x + div_q[17:0] - ((doe == 18'd146096) ? 18'd1 : 18'd0);
                step <= step_t'(step + 4'd1);
              end
              ST_YOE: begin
                yoe  <= div_q[8:0];
                step <= step_t'(step + 4'd1);
              end
              ST_C100: begin
                doy  <= 9'(doe - (yoe_terms - 18'(div_q[2:0])));
                step <= step_t'(step + 4'd1);
              end
              ST_MP: begin
                mp   <= div_q[3:0];
                step <= step_t'(step + 4'd1);
              end
              ST_DOM: begin
                dom   <= 5'(doy - div_q[8:0] + 9'd1);
                state <= OUT;
              end
              default: begin
                state <= IDLE;
              end
            endcase
          end
        end
        OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.year           <= year_next;
            out_data.month          <= (mp < 4'd10) ? mp + 4'd2 : mp - 4'd10;
            out_data.day_of_month   <= dom;
            out_data.hour           <= hr;
            out_data.minute         <= mn;
            out_data.second         <= sc;
            out_data.millisecond    <= ms;
            out_data.weekday        <= wd;
            out_data.applied_offset <= tz;
            state                   <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/em2c_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the epoch conversion unit
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module em2c_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input em2c_pkg::out_item_t out_data
);

  // An accepted item keeps the input stalled while it is converted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an item was accepted");

  // A waiting result is neither dropped nor altered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // Fields of a result stay within the calendar.
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.month <= 4'd11 && out_data.hour <= 5'd23
                  && out_data.weekday <= 3'd6 && out_data.day_of_month != 5'd0)
    else $error("result field out of range");

  // Reset leaves no result behind.
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind epoch_ms_to_calendar_fields_unit em2c_checker u_em2c_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
